@@ design/ikey_pkg.sv @@
// ----------------------------------------------------------------------------
// ikey_pkg - iambic keyer shared definitions
// Timer width, phase and element codes, register indexes, reset values and
// the reciprocal used for the early-latch percentage.
// ----------------------------------------------------------------------------
package ikey_pkg;

  localparam int TIMER_WIDTH = 16;

  // keyer phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DIT   = 3'd1,
    PH_DAH   = 3'd2,
    PH_START = 3'd3,
    PH_KEYED = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  // element chosen at an item
  typedef enum logic [1:0] {
    EB_NONE = 2'd0,
    EB_DIT  = 2'd1,
    EB_DAH  = 2'd2
  } elem_t;

  // keyer modes
  localparam logic [1:0] MODE_A     = 2'd0;
  localparam logic [1:0] MODE_B     = 2'd1;
  localparam logic [1:0] MODE_ULTIM = 2'd2;
  localparam logic [1:0] MODE_NOSQZ = 2'd3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DIT_LEN    = 3'd0,
    REG_MODE       = 3'd1,
    REG_DOT_PCT    = 3'd2,
    REG_DASH_PCT   = 3'd3,
    REG_LATENCY    = 3'd4,
    REG_CHAR_SPACE = 3'd5,
    REG_WORD_GAP   = 3'd6,
    REG_PAD_NORMAL = 3'd7
  } reg_idx_t;

  localparam int CFG_WIDTH = 14;

  // reset values
  localparam logic [7:0]  RST_DIT_LEN    = 8'd60;
  localparam logic [1:0]  RST_MODE       = MODE_B;
  localparam logic [6:0]  RST_DOT_PCT    = 7'd75;
  localparam logic [6:0]  RST_DASH_PCT   = 7'd45;
  localparam logic [3:0]  RST_LATENCY    = 4'd4;
  localparam logic [3:0]  RST_CHAR_SPACE = 4'd0;
  localparam logic [13:0] RST_WORD_GAP   = 14'd300;

  // x/100 = (x>>2)/25; (y*41944)>>20 is exact for y < 43690
  localparam logic [15:0] DIV25_MUL   = 16'd41944;
  localparam int          DIV25_SHIFT = 20;

  // latches bits
  localparam int L_DIT     = 0;
  localparam int L_DAH     = 1;
  localparam int L_LASTDIT = 2;

endpackage

@@ design/iambic_morse_keyer.sv @@
// ----------------------------------------------------------------------------
// iambic_morse_keyer - iambic Morse keyer, modes A, B, ultimatic, non-squeeze
// Paddle samples with a millisecond tick flag in, one keying result per item.
// ----------------------------------------------------------------------------
// One result item per input item. An accepted item sits in an input register
// until the keyer steps, the keyer state is updated from it by a single pass
// of logic and the result lands in an output register, from which it is
// presented. A new item is taken every cycle while the output side keeps up.
// While a result waits, the input register takes at most one more item and
// then holds in_tready low until the result is accepted. Register writes act
// on the early-latch point only once the products dit*pct, held in registers,
// have been updated; the one multiply-by-reciprocal for the percentage divide
// sits in the element start.
// ----------------------------------------------------------------------------
module iambic_morse_keyer
  import ikey_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] tick, [1] left_paddle, [2] right_paddle
  // result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] key_down, [2:1] element_begin,
                                           // [3] word_end, [4] paddle_busy
  output logic                 out_tlast,  // char_end
  // register writes
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [CFG_WIDTH-1:0] cfg_wdata
);

  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  // ---------------------------------------------------------------- config
  logic [7:0]  dit_len_r;
  logic [1:0]  mode_r;
  logic [6:0]  dot_pct_r;
  logic [6:0]  dash_pct_r;
  logic [3:0]  latency_r;
  logic [3:0]  char_space_r;
  logic [13:0] word_gap_r;
  logic        pad_normal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dit_len_r    <= RST_DIT_LEN;
      mode_r       <= RST_MODE;
      dot_pct_r    <= RST_DOT_PCT;
      dash_pct_r   <= RST_DASH_PCT;
      latency_r    <= RST_LATENCY;
      char_space_r <= RST_CHAR_SPACE;
      word_gap_r   <= RST_WORD_GAP;
      pad_normal_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_DIT_LEN:    dit_len_r    <= cfg_wdata[7:0];
        REG_MODE:       mode_r       <= cfg_wdata[1:0];
        REG_DOT_PCT:    dot_pct_r    <= cfg_wdata[6:0];
        REG_DASH_PCT:   dash_pct_r   <= cfg_wdata[6:0];
        REG_LATENCY:    latency_r    <= cfg_wdata[3:0];
        REG_CHAR_SPACE: char_space_r <= cfg_wdata[3:0];
        REG_WORD_GAP:   word_gap_r   <= cfg_wdata;
        REG_PAD_NORMAL: pad_normal_r <= cfg_wdata[0];
      endcase
    end
  end

  // element length times early percentage, one multiplier each
  logic [9:0]  dah_len;
  logic [14:0] prod_dit_r;
  logic [16:0] prod_dah_r;

  assign dah_len = {1'b0, dit_len_r, 1'b0} + {2'b00, dit_len_r};

  always_ff @(posedge clk) begin
    prod_dit_r <= 15'(dit_len_r) * 15'(dot_pct_r);
    prod_dah_r <= 17'(dah_len) * 17'(dash_pct_r);
  end

  // ---------------------------------------------------------- handshakes
  logic in_v_r, out_v_r, adv, step;
  logic in_tick_r, in_left_r, in_right_r;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !in_v_r || adv;
  assign step      = in_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (adv)       out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_tick_r  <= in_tdata[0];
      in_left_r  <= in_tdata[1];
      in_right_r <= in_tdata[2];
    end
  end

  // --------------------------------------------------------------- state
  phase_t                 phase_r, phase_nxt;
  logic [2:0]             latches_r, latches_nxt;
  logic                   first_dit_r, first_dit_nxt;
  logic                   keyed_r, keyed_nxt;
  logic                   word_armed_r, word_armed_nxt;
  logic [TIMER_WIDTH-1:0] elem_tm_r, elem_tm_nxt;
  logic [TIMER_WIDTH-1:0] early_tm_r, early_tm_nxt;
  logic [TIMER_WIDTH-1:0] lat_tm_r, lat_tm_nxt;
  logic [TIMER_WIDTH-1:0] space_tm_r, space_tm_nxt;
  logic [TIMER_WIDTH-1:0] word_tm_r, word_tm_nxt;

  function automatic logic [TIMER_WIDTH-1:0] dec_sat(input logic [TIMER_WIDTH-1:0] v);
    dec_sat = (v != '0) ? v - 1'b1 : v;
  endfunction

  function automatic logic [TIMER_WIDTH-1:0] inc_sat(input logic [TIMER_WIDTH-1:0] v);
    inc_sat = (v != TMAX) ? v + 1'b1 : v;
  endfunction

  // paddles after optional swap
  logic dit_p, dah_p;
  assign dit_p = pad_normal_r ? in_left_r  : in_right_r;
  assign dah_p = pad_normal_r ? in_right_r : in_left_r;

  // timers after this item's tick
  logic in_elem_ph, in_gap_ph;
  logic [TIMER_WIDTH-1:0] t_elem, t_early, t_lat, t_space, t_word;

  assign in_gap_ph  = (phase_r == PH_GAP);
  assign in_elem_ph = (phase_r == PH_KEYED) || in_gap_ph;
  assign t_elem  = (in_tick_r && in_elem_ph) ? dec_sat(elem_tm_r)  : elem_tm_r;
  assign t_early = (in_tick_r && in_elem_ph) ? dec_sat(early_tm_r) : early_tm_r;
  assign t_lat   = (in_tick_r && in_gap_ph)  ? dec_sat(lat_tm_r)   : lat_tm_r;
  assign t_space = in_tick_r ? dec_sat(space_tm_r) : space_tm_r;
  assign t_word  = in_tick_r ? dec_sat(word_tm_r)  : word_tm_r;

  // element start loads: length and early-latch point
  logic        start_dah;
  logic [9:0]  len_w;
  logic [16:0] prod_sel;
  logic [30:0] recip;
  logic [10:0] pct_q;
  logic [TIMER_WIDTH-1:0] early_load;

  assign start_dah = (phase_r == PH_DAH);
  assign len_w     = start_dah ? dah_len : {2'b00, dit_len_r};
  assign prod_sel  = start_dah ? prod_dah_r : {2'b00, prod_dit_r};
  assign recip     = 31'(prod_sel[16:2]) * 31'(DIV25_MUL);
  assign pct_q     = recip[30:DIV25_SHIFT];

  always_comb begin
    priority if (mode_r == MODE_B) early_load = TIMER_WIDTH'(pct_q) + TIMER_WIDTH'(2);
    else if (mode_r == MODE_NOSQZ) early_load = TIMER_WIDTH'(3);
    else                           early_load = TIMER_WIDTH'(len_w);
  end

  // gap loads
  logic [11:0] lat_prod;
  logic [8:0]  lat_load;
  logic [11:0] space_load;
  logic [8:0]  gap_load;
  logic [14:0] word_load;

  assign lat_prod   = 12'(latency_r - 4'd1) * 12'(dit_len_r);
  assign lat_load   = (latency_r != '0) ? lat_prod[11:3] : '0;
  assign space_load = 12'(char_space_r) * 12'(dit_len_r) + 12'd1;
  assign gap_load   = {1'b0, dit_len_r} + 9'd1;
  assign word_load  = {1'b0, word_gap_r} + 15'd1;

  // shared decisions
  logic       idle_word, press, cs_hold, gap_lat, gap_done, next_dah;
  logic [2:0] opp_latch, merged;
  elem_t      gap_sel;

  assign idle_word = word_armed_r && (t_word == '0);
  assign press     = dit_p || dah_p;
  assign cs_hold   = (char_space_r != '0) && (t_space != '0);
  assign gap_lat   = (t_lat != '0);
  assign gap_done  = !gap_lat && (t_elem == '0);

  // inside the latency window only the paddle opposite the last element latches
  always_comb begin
    opp_latch = latches_r;
    if (latches_r[L_LASTDIT]) opp_latch[L_DAH] = latches_r[L_DAH] | dah_p;
    else                      opp_latch[L_DIT] = latches_r[L_DIT] | dit_p;
  end

  assign merged = gap_lat ? opp_latch : (latches_r | {1'b0, dah_p, dit_p});

  // squeeze resolution per mode
  always_comb begin
    priority if (mode_r == MODE_NOSQZ) next_dah = !first_dit_r;
    else if (mode_r == MODE_ULTIM)     next_dah = first_dit_r;
    else                               next_dah = merged[L_LASTDIT];
  end

  always_comb begin
    priority if (merged[L_DIT] && merged[L_DAH]) gap_sel = next_dah ? EB_DAH : EB_DIT;
    else if (merged[L_DIT])                     gap_sel = EB_DIT;
    else if (merged[L_DAH])                     gap_sel = EB_DAH;
    else                                        gap_sel = EB_NONE;
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    latches_nxt    = latches_r;
    first_dit_nxt  = first_dit_r;
    keyed_nxt      = keyed_r;
    word_armed_nxt = word_armed_r;
    elem_tm_nxt    = t_elem;
    early_tm_nxt   = t_early;
    lat_tm_nxt     = t_lat;
    space_tm_nxt   = t_space;
    word_tm_nxt    = t_word;
    unique case (phase_r)
      PH_DIT, PH_DAH: begin
        if (!cs_hold) begin
          latches_nxt  = {!start_dah, 2'b00};
          elem_tm_nxt  = TIMER_WIDTH'(len_w);
          early_tm_nxt = early_load;
          phase_nxt    = PH_START;
        end
      end
      PH_START: begin
        elem_tm_nxt  = inc_sat(t_elem);
        early_tm_nxt = inc_sat(t_early);
        keyed_nxt    = 1'b1;
        phase_nxt    = PH_KEYED;
      end
      PH_KEYED: begin
        if (t_elem == '0) begin
          keyed_nxt   = 1'b0;
          elem_tm_nxt = TIMER_WIDTH'(gap_load);
          lat_tm_nxt  = TIMER_WIDTH'(lat_load);
          phase_nxt   = PH_GAP;
        end else if (t_early == '0) begin
          latches_nxt = opp_latch;
        end
      end
      PH_GAP: begin
        latches_nxt = merged;
        if (gap_done) begin
          unique case (gap_sel)
            EB_DIT: phase_nxt = PH_DIT;
            EB_DAH: phase_nxt = PH_DAH;
            default: begin
              phase_nxt      = PH_IDLE;
              latches_nxt    = '0;
              word_tm_nxt    = TIMER_WIDTH'(word_load);
              word_armed_nxt = 1'b1;
              if (char_space_r != '0) space_tm_nxt = TIMER_WIDTH'(space_load);
            end
          endcase
        end
      end
      default: begin  // idle
        if (idle_word) begin
          word_armed_nxt = 1'b0;
        end else if (press) begin
          latches_nxt   = latches_r | {1'b0, dah_p, dit_p};
          first_dit_nxt = dit_p;
          phase_nxt     = dit_p ? PH_DIT : PH_DAH;
        end
      end
    endcase
  end

  // result of this item
  elem_t elem_w;
  logic  cend_w, wend_w;

  always_comb begin
    elem_w = EB_NONE;
    cend_w = 1'b0;
    wend_w = 1'b0;
    unique case (phase_r)
      PH_DIT, PH_DAH, PH_START, PH_KEYED: ;
      PH_GAP: begin
        if (gap_done) begin
          elem_w = gap_sel;
          cend_w = (gap_sel == EB_NONE);
        end
      end
      default: begin
        if (idle_word) wend_w = 1'b1;
        else if (press) elem_w = dit_p ? EB_DIT : EB_DAH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      latches_r    <= '0;
      first_dit_r  <= 1'b0;
      keyed_r      <= 1'b0;
      word_armed_r <= 1'b0;
      elem_tm_r    <= '0;
      early_tm_r   <= '0;
      lat_tm_r     <= '0;
      space_tm_r   <= '0;
      word_tm_r    <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      latches_r    <= latches_nxt;
      first_dit_r  <= first_dit_nxt;
      keyed_r      <= keyed_nxt;
      word_armed_r <= word_armed_nxt;
      elem_tm_r    <= elem_tm_nxt;
      early_tm_r   <= early_tm_nxt;
      lat_tm_r     <= lat_tm_nxt;
      space_tm_r   <= space_tm_nxt;
      word_tm_r    <= word_tm_nxt;
    end
  end

  // output register
  logic  key_r, cend_r, wend_r, busy_r;
  elem_t elem_r;

  always_ff @(posedge clk) begin
    if (step) begin
      key_r  <= keyed_nxt;
      elem_r <= elem_w;
      cend_r <= cend_w;
      wend_r <= wend_w;
      busy_r <= |latches_nxt[1:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, busy_r, wend_r, elem_r, key_r};
  assign out_tlast  = cend_r;

`ifndef NO_ASSERTIONS
  // the key is down exactly while an element is being sent
  a_key_phase: assert property (@(posedge clk) disable iff (!rst_n)
    keyed_r == (phase_r == PH_KEYED))
    else $error("keyed flag out of step with phase");

  // a chosen element always leads to its pending phase
  a_elem_dit: assert property (@(posedge clk) disable iff (!rst_n)
    step && elem_w == EB_DIT |=> phase_r == PH_DIT)
    else $error("dit chosen but phase not dit");

  a_elem_dah: assert property (@(posedge clk) disable iff (!rst_n)
    step && elem_w == EB_DAH |=> phase_r == PH_DAH)
    else $error("dah chosen but phase not dah");

  // character end returns to idle with latches clear and word timer armed
  a_char_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && cend_w |=> phase_r == PH_IDLE && latches_r == '0 && word_armed_r)
    else $error("character end left keyer busy");

  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r)
    else $error("stalled result lost");
`endif

endmodule
